// ----- src/nts_pkg.sv -----
package nts_pkg;

	// field widths
	localparam int unsigned PHASE_BITS = 24;
	localparam int unsigned FREQ_W     = 16;
	localparam int unsigned DUR_W      = 16;
	localparam int unsigned VOL_W      = 4;
	localparam int unsigned WAVE_W     = 2;
	localparam int unsigned SR_W       = 17;
	localparam int unsigned SAMPLE_W   = 15;

	// note state widths
	localparam int unsigned LEN_W  = 23;
	localparam int unsigned RAMP_W = LEN_W - 4;
	localparam int unsigned PROD_W = DUR_W + SR_W;
	localparam int unsigned AMP_W  = 14;
	localparam int unsigned MAG_W  = 14;

	// note length: divide by 1000 as a three-bit shift, then times 2^37/125 rounded up
	localparam int unsigned LEN_PRE_SH = 3;
	localparam int unsigned LEN_RCP_W  = 31;
	localparam int unsigned LEN_RCP_SH = 37;
	localparam int unsigned LEN_RCP_PW = PROD_W - LEN_PRE_SH + LEN_RCP_W;

	// datapath widths
	localparam int unsigned VW     = PHASE_BITS + 3;
	localparam int unsigned XW     = PHASE_BITS + 1 + AMP_W;
	localparam int unsigned XH_W   = XW - PHASE_BITS;
	localparam int unsigned P1_W   = XH_W + RAMP_W;
	localparam int unsigned P2_W   = PHASE_BITS + RAMP_W;
	localparam int unsigned YW     = P1_W + 1;
	localparam int unsigned INCD_W = PHASE_BITS + FREQ_W;
	localparam int unsigned DIVD_W = (INCD_W > YW) ? INCD_W : YW;
	localparam int unsigned DIVS_W = RAMP_W;
	localparam int unsigned DCNT_W = $clog2(DIVD_W + 1);

	// constants
	localparam logic [LEN_W-1:0]     LEN_MAX    = '1;
	localparam logic [AMP_W-1:0]     AMP_STEP   = AMP_W'(600);
	localparam logic [31:0]          LCG_MUL    = 32'd1103515245;
	localparam logic [31:0]          LCG_ADD    = 32'd12345;
	localparam logic [31:0]          NOISE_SEED = 32'h0001_2345;
	localparam logic [SR_W-1:0]      SR_RESET   = SR_W'(44100);
	localparam logic [LEN_RCP_W-1:0] LEN_RCP    = 31'd1099511628;

	// request kinds
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	// waveforms
	localparam logic [WAVE_W-1:0] WAVE_SQUARE   = 2'd0;
	localparam logic [WAVE_W-1:0] WAVE_TRIANGLE = 2'd1;
	localparam logic [WAVE_W-1:0] WAVE_SAW      = 2'd2;
	localparam logic [WAVE_W-1:0] WAVE_NOISE    = 2'd3;

	// divider operand selection
	localparam logic [1:0] DIV_INC = 2'd1;
	localparam logic [1:0] DIV_ENV = 2'd2;

	typedef struct packed {
		logic              req_type;
		logic [FREQ_W-1:0] freq_hz;
		logic [DUR_W-1:0]  dur_ms;
		logic [VOL_W-1:0]  volume;
		logic [WAVE_W-1:0] waveform;
	} req_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last_of_note;
		logic                       playing;
	} rsp_t;

	typedef struct packed {
		logic       capture;
		logic       len_mul;
		logic       div_start;
		logic [1:0] div_sel;
		logic       len_store;
		logic       inc_store;
		logic       inc_zero;
		logic       wave;
		logic       mul_amp;
		logic       mul_env;
		logic       sum;
		logic       res_write;
		logic       res_note;
		logic       advance;
	} dp_cmd_t;

	typedef struct packed {
		logic active;
		logic shaped;
		logic sr_zero;
		logic div_busy;
		logic out_free;
	} dp_stat_t;

endpackage

// ----- src/nts_div.sv -----
module nts_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [nts_pkg::DIVD_W-1:0] dividend,
	input  logic [nts_pkg::DIVS_W-1:0] divisor,
	output logic                       busy,
	output logic [nts_pkg::DIVD_W-1:0] quotient
);
	import nts_pkg::*;

	logic [DIVD_W-1:0] quo_q;
	logic [DIVS_W-1:0] rem_q;
	logic [DIVS_W-1:0] dvs_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              busy_q;
	logic [DIVS_W:0]   trial;
	logic              fits;

	// one restoring step per cycle
	assign trial = {rem_q, quo_q[DIVD_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DCNT_W'(DIVD_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - DCNT_W'(1);
			if (cnt_q == DCNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// operands and partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVD_W-2:0], fits};
			rem_q <= fits ? DIVS_W'(trial - {1'b0, dvs_q}) : trial[DIVS_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

// ----- src/nts_dp.sv -----
module nts_dp (
	input  logic                     clk,
	input  logic                     arst_n,
	input  nts_pkg::dp_cmd_t         cmd,
	output nts_pkg::dp_stat_t        stat,
	input  nts_pkg::req_t            req,
	input  logic                     cfg_we,
	input  logic [nts_pkg::SR_W-1:0] cfg_wdata,
	input  logic                     rsp_stall,
	output logic                     rsp_valid,
	output nts_pkg::rsp_t            rsp
);
	import nts_pkg::*;

	localparam logic signed [VW-1:0] FULL = VW'(1) << PHASE_BITS;

	// configuration and note state
	logic [SR_W-1:0]       sr_q;
	logic [PHASE_BITS-1:0] phase_q;
	logic [PHASE_BITS-1:0] inc_q;
	logic [LEN_W-1:0]      len_q;
	logic [LEN_W-1:0]      idx_q;
	logic [RAMP_W-1:0]     ramp_q;
	logic [VOL_W-1:0]      vol_q;
	logic [WAVE_W-1:0]     wave_q;
	logic [31:0]           noise_q;

	// load buffer
	logic [FREQ_W-1:0] ld_freq_q;
	logic [DUR_W-1:0]  ld_dur_q;
	logic [VOL_W-1:0]  ld_vol_q;
	logic [WAVE_W-1:0] ld_wave_q;
	logic [PROD_W-1:0] prod_q;

	// sample working registers
	logic                  neg_q;
	logic [PHASE_BITS:0]   absv_q;
	logic                  shaped_q;
	logic [RAMP_W-1:0]     en_q;
	logic [XW-1:0]         x_q;
	logic [P1_W-1:0]       p1_q;
	logic [P2_W-1:0]       p2_q;
	logic [YW-1:0]         y_q;

	// output register
	logic rsp_valid_q;
	rsp_t rsp_q;

	// divider
	logic [DIVD_W-1:0] div_dividend;
	logic [DIVS_W-1:0] div_divisor;
	logic              div_busy;
	logic [DIVD_W-1:0] div_quo;

	logic [LEN_RCP_PW-1:0]    len_rcp;
	logic [LEN_W-1:0]         len_new;
	logic [31:0]              noise_nxt;
	logic signed [VW-1:0]     p_ext;
	logic signed [VW-1:0]     vn;
	logic signed [VW-1:0]     vabs;
	logic                     ramp_head;
	logic                     ramp_tail;
	logic [AMP_W-1:0]         amp;
	logic [MAG_W-1:0]         mag;
	logic signed [SAMPLE_W-1:0] smp;

	nts_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	// divider operand selection
	always_comb begin
		unique case (cmd.div_sel)
			DIV_INC: begin
				div_dividend = DIVD_W'({ld_freq_q, {PHASE_BITS{1'b0}}});
				div_divisor  = DIVS_W'(sr_q);
			end
			DIV_ENV: begin
				div_dividend = DIVD_W'(y_q);
				div_divisor  = ramp_q;
			end
			default: begin
				div_dividend = '0;
				div_divisor  = '0;
			end
		endcase
	end

	// note length: product over 1000 by reciprocal, with saturation
	assign len_rcp = LEN_RCP_PW'(prod_q[PROD_W-1:LEN_PRE_SH]) * LEN_RCP_PW'(LEN_RCP);
	assign len_new = (|len_rcp[LEN_RCP_PW-1:LEN_RCP_SH+LEN_W]) ? LEN_MAX
	                                                          : len_rcp[LEN_RCP_SH+LEN_W-1:LEN_RCP_SH];

	// wave value for the current phase
	assign noise_nxt = noise_q * LCG_MUL + LCG_ADD;
	assign p_ext     = $signed({3'b000, phase_q});

	always_comb begin
		unique case (wave_q)
			WAVE_SQUARE:   vn = phase_q[PHASE_BITS-1] ? -FULL : FULL;
			WAVE_TRIANGLE: vn = phase_q[PHASE_BITS-1] ? (FULL + (FULL <<< 1)) - (p_ext <<< 2)
			                                          : (p_ext <<< 2) - FULL;
			WAVE_SAW:      vn = (p_ext <<< 1) - FULL;
			WAVE_NOISE:    vn = noise_nxt[16] ? FULL : -FULL;
			default:       vn = '0;
		endcase
	end

	assign vabs = vn[VW-1] ? -vn : vn;

	// envelope region
	assign ramp_head = idx_q < LEN_W'(ramp_q);
	assign ramp_tail = (ramp_q != '0) && (idx_q > (len_q - LEN_W'(ramp_q)));

	assign amp = AMP_W'(vol_q) * AMP_STEP;

	// result magnitude and sign
	assign mag = shaped_q ? div_quo[MAG_W-1:0] : x_q[PHASE_BITS+MAG_W-1:PHASE_BITS];
	assign smp = neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

	// configuration and note state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sr_q    <= SR_RESET;
			phase_q <= '0;
			inc_q   <= '0;
			len_q   <= '0;
			idx_q   <= '0;
			ramp_q  <= '0;
			vol_q   <= '0;
			wave_q  <= WAVE_SQUARE;
			noise_q <= NOISE_SEED;
		end else begin
			if (cfg_we) begin
				sr_q <= cfg_wdata;
			end
			if (cmd.len_store) begin
				len_q   <= len_new;
				ramp_q  <= len_new[LEN_W-1:4];
				idx_q   <= '0;
				phase_q <= '0;
				if (ld_freq_q == '0) begin
					vol_q  <= '0;
					wave_q <= WAVE_SQUARE;
				end else begin
					vol_q  <= ld_vol_q;
					wave_q <= ld_wave_q;
				end
			end
			if (cmd.inc_store) begin
				inc_q <= div_quo[PHASE_BITS-1:0];
			end else if (cmd.inc_zero) begin
				inc_q <= '0;
			end
			if (cmd.wave && (wave_q == WAVE_NOISE)) begin
				noise_q <= noise_nxt;
			end
			if (cmd.advance) begin
				idx_q   <= idx_q + LEN_W'(1);
				phase_q <= phase_q + inc_q;
			end
		end
	end

	// load buffer and sample pipeline
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ld_freq_q <= req.freq_hz;
			ld_dur_q  <= req.dur_ms;
			ld_vol_q  <= req.volume;
			ld_wave_q <= req.waveform;
		end
		if (cmd.len_mul) begin
			prod_q <= PROD_W'(ld_dur_q) * PROD_W'(sr_q);
		end
		if (cmd.wave) begin
			neg_q    <= vn[VW-1];
			absv_q   <= vabs[PHASE_BITS:0];
			shaped_q <= ramp_head || ramp_tail;
			en_q     <= ramp_head ? idx_q[RAMP_W-1:0] : RAMP_W'(len_q - idx_q);
		end
		if (cmd.mul_amp) begin
			x_q <= XW'(absv_q) * XW'(amp);
		end
		if (cmd.mul_env) begin
			p1_q <= P1_W'(x_q[XW-1:PHASE_BITS]) * P1_W'(en_q);
			p2_q <= P2_W'(x_q[PHASE_BITS-1:0]) * P2_W'(en_q);
		end
		if (cmd.sum) begin
			y_q <= YW'(p1_q) + YW'(p2_q[P2_W-1:PHASE_BITS]);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.res_write) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_write) begin
			if (cmd.res_note) begin
				rsp_q.sample       <= smp;
				rsp_q.last_of_note <= (idx_q + LEN_W'(1)) == len_q;
				rsp_q.playing      <= 1'b1;
			end else begin
				rsp_q.sample       <= '0;
				rsp_q.last_of_note <= 1'b0;
				rsp_q.playing      <= 1'b0;
			end
		end
	end

	// status
	assign stat.active   = idx_q < len_q;
	assign stat.shaped   = shaped_q;
	assign stat.sr_zero  = sr_q == '0;
	assign stat.div_busy = div_busy;
	assign stat.out_free = !rsp_valid_q || !rsp_stall;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- src/nts_ctrl.sv -----
module nts_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_type,
	output logic               req_stall,
	output nts_pkg::dp_cmd_t   cmd,
	input  nts_pkg::dp_stat_t  stat
);
	import nts_pkg::*;

	localparam logic [3:0] ST_IDLE         = 4'd0;
	localparam logic [3:0] ST_LD_MUL       = 4'd1;
	localparam logic [3:0] ST_LD_LEN       = 4'd2;
	localparam logic [3:0] ST_LD_INC       = 4'd4;
	localparam logic [3:0] ST_LD_INC_WAIT  = 4'd5;
	localparam logic [3:0] ST_WAVE         = 4'd6;
	localparam logic [3:0] ST_MUL_AMP      = 4'd7;
	localparam logic [3:0] ST_MUL_ENV      = 4'd8;
	localparam logic [3:0] ST_SUM          = 4'd9;
	localparam logic [3:0] ST_DIV_ENV      = 4'd10;
	localparam logic [3:0] ST_DIV_WAIT     = 4'd11;
	localparam logic [3:0] ST_EMIT         = 4'd12;
	localparam logic [3:0] ST_EMIT_IDLE    = 4'd13;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       accept;

	assign req_stall = state_q != ST_IDLE;
	assign accept    = req_valid && !req_stall;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.div_sel = DIV_INC;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.capture = 1'b1;
					if (req_type == REQ_LOAD) begin
						state_d = ST_LD_MUL;
					end else if (stat.active) begin
						state_d = ST_WAVE;
					end else begin
						state_d = ST_EMIT_IDLE;
					end
				end
			end
			ST_LD_MUL: begin
				cmd.len_mul = 1'b1;
				state_d     = ST_LD_LEN;
			end
			ST_LD_LEN: begin
				cmd.len_store = 1'b1;
				state_d       = ST_LD_INC;
			end
			ST_LD_INC: begin
				if (stat.sr_zero) begin
					cmd.inc_zero = 1'b1;
					state_d      = ST_IDLE;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_INC;
					state_d       = ST_LD_INC_WAIT;
				end
			end
			ST_LD_INC_WAIT: begin
				cmd.div_sel = DIV_INC;
				if (!stat.div_busy) begin
					cmd.inc_store = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_WAVE: begin
				cmd.wave = 1'b1;
				state_d  = ST_MUL_AMP;
			end
			ST_MUL_AMP: begin
				cmd.mul_amp = 1'b1;
				state_d     = stat.shaped ? ST_MUL_ENV : ST_EMIT;
			end
			ST_MUL_ENV: begin
				cmd.mul_env = 1'b1;
				state_d     = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_DIV_ENV;
			end
			ST_DIV_ENV: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_ENV;
				state_d       = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				cmd.div_sel = DIV_ENV;
				if (!stat.div_busy) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.res_write = 1'b1;
					cmd.res_note  = 1'b1;
					cmd.advance   = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_EMIT_IDLE: begin
				if (stat.out_free) begin
					cmd.res_write = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// the divider is never restarted while it is still working
	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !stat.div_busy)
		else $error("divider started while busy");

	// a started division is seen as busy on the next cycle
	a_div_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> stat.div_busy)
		else $error("divider did not go busy after start");

	// a result is only written when the output register can take it
	a_res_write_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_write |-> stat.out_free)
		else $error("result written over a pending one");

	// a tick with no note in progress goes straight to the silent result
	a_idle_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req_type == REQ_TICK) && !stat.active) |=> (state_q == ST_EMIT_IDLE))
		else $error("idle tick did not yield a silent result");

endmodule

// ----- src/note_tone_synth_unit.sv -----
// channel   direction  handshake                 payload
// req       in         req_valid / req_stall     nts_pkg::req_t (load or tick request)
// rsp       out        rsp_valid / rsp_stall     nts_pkg::rsp_t (one sample per tick)
// cfg       in         cfg_we                    cfg_wdata, sample rate
//
// tick: on the flat part of a note the result follows WAVE and MUL_AMP; inside the attack
//   or decay ramp MUL_ENV, SUM and the one-bit-per-cycle divider come first; with no note
//   running a silent result is written; the next request can be taken as the result appears
// load: no result; the next request waits for LD_MUL, LD_LEN, LD_INC and the divider (not at sample rate 0)
// reset clears the note state, seeds the noise generator and sets 44100 samples/s
// a stalled result waits in the output register; only the next finished tick waits on it
module note_tone_synth_unit (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_stall,
	input  nts_pkg::req_t            req,
	output logic                     rsp_valid,
	input  logic                     rsp_stall,
	output nts_pkg::rsp_t            rsp,
	input  logic                     cfg_we,
	input  logic [nts_pkg::SR_W-1:0] cfg_wdata
);
	import nts_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequencer
	nts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_type  (req.req_type),
		.req_stall (req_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	// arithmetic, note state and output register
	nts_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule
